@@ design/rmth_pkg.sv @@
package rmth_pkg;

	localparam int HEAP_DEPTH  = 512;
	localparam int SAMPLE_BITS = 16;
	localparam int SIZE_W      = $clog2(HEAP_DEPTH + 1);
	localparam int CAPACITY    = 2 * HEAP_DEPTH - 1;
	localparam int MED_W       = 17;
	localparam int COUNT_W     = 10;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [SIZE_W-1:0] heap_size_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_PUSH,
		CELL_POP
	} cell_op_t;

endpackage

@@ design/rmth_cell.sv @@
module rmth_cell
	import rmth_pkg::*;
(
	input  logic     clk,
	input  cell_op_t op,
	input  logic     desc,
	input  logic     vacant,
	input  sample_t  din,
	input  sample_t  prev_val,
	input  logic     prev_take,
	input  sample_t  next_val,
	output sample_t  val,
	output logic     take
);

	sample_t val_q;

	// descending row takes the sample below larger values, ascending below smaller ones
	assign take = vacant || (desc ? (val_q < din) : (val_q > din));
	assign val  = val_q;

	always_ff @(posedge clk) begin
		case (op)
			CELL_INSERT: begin
				if (take) begin
					val_q <= prev_take ? prev_val : din;
				end
			end
			CELL_PUSH: val_q <= prev_val;
			CELL_POP:  val_q <= next_val;
			default:   val_q <= val_q;
		endcase
	end

endmodule

@@ design/rmth_chain.sv @@
module rmth_chain
	import rmth_pkg::*;
(
	input  logic       clk,
	input  cell_op_t   op,
	input  logic       desc,
	input  sample_t    din,
	input  heap_size_t size,
	output sample_t    top
);

	sample_t val  [HEAP_DEPTH];
	logic    take [HEAP_DEPTH];

	for (genvar i = 0; i < HEAP_DEPTH; i++) begin : g_cell
		sample_t prev_val;
		logic    prev_take;
		sample_t next_val;
		logic    vacant;

		assign vacant = (SIZE_W'(i) >= size);

		if (i == 0) begin : g_head
			assign prev_val  = din;
			assign prev_take = 1'b0;
		end else begin : g_body
			assign prev_val  = val[i-1];
			assign prev_take = take[i-1];
		end

		if (i == HEAP_DEPTH - 1) begin : g_tail
			assign next_val = val[i];
		end else begin : g_inner
			assign next_val = val[i+1];
		end

		rmth_cell u_cell (
			.clk       (clk),
			.op        (op),
			.desc      (desc),
			.vacant    (vacant),
			.din       (din),
			.prev_val  (prev_val),
			.prev_take (prev_take),
			.next_val  (next_val),
			.val       (val[i]),
			.take      (take[i])
		);
	end

	assign top = val[0];

endmodule

@@ design/running_median_two_heaps.sv @@
// running median of a stream of signed samples
// input channel: in_valid / in_ready with sample; one transfer per sample
// output channel: out_valid / out_ready with median_doubled, sample_count and
// rejected; exactly one result per input transfer, in order
// the lower half of the samples sits in a descending row of cells, the upper
// half in an ascending row; the head cell of each row is the heap top
// each item goes through these steps: accept, insert into one row in a
// single parallel shift, rebalance by moving one head across, then load
// the output register once it is free; the result shows in the cycle after
// that; the step sequencer keeps one item in work at a time
// median_doubled is twice the median (one implied fraction bit), 0 when empty
// at most 1023 samples are held; a sample beyond that is dropped with
// rejected set and the previous median and count reported
// reset clears the sizes and the sequencer; cell contents need no reset
// a stalled receiver holds the result; the next sample is taken meanwhile
// but its result waits in the last step until the output register is free
module running_median_two_heaps
	import rmth_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [MED_W-1:0] median_doubled,
	output logic [COUNT_W-1:0]      sample_count,
	output logic                    rejected
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INSERT,
		ST_BALANCE,
		ST_DONE
	} state_t;

	state_t     state_q;
	sample_t    sample_q;
	heap_size_t lsize_q;
	heap_size_t usize_q;
	logic       rej_q;

	cell_op_t   lop;
	cell_op_t   uop;
	sample_t    ldin;
	sample_t    udin;
	sample_t    ltop;
	sample_t    utop;
	logic [SIZE_W:0] total;
	logic       full;
	logic       to_lower;
	logic       lower_heavy;
	logic       upper_heavy;
	logic signed [MED_W-1:0] median;

	assign total       = (SIZE_W+1)'(lsize_q) + (SIZE_W+1)'(usize_q);
	assign full        = (total == (SIZE_W+1)'(CAPACITY));
	assign to_lower    = (lsize_q == '0) || (ltop >= sample_q);
	assign lower_heavy = ((SIZE_W+1)'(lsize_q) > (SIZE_W+1)'(usize_q) + 1'b1);
	assign upper_heavy = ((SIZE_W+1)'(usize_q) > (SIZE_W+1)'(lsize_q) + 1'b1);
	assign in_ready    = (state_q == ST_IDLE);

	assign ldin = (state_q == ST_BALANCE) ? utop : sample_q;
	assign udin = (state_q == ST_BALANCE) ? ltop : sample_q;

	always_comb begin
		lop = CELL_HOLD;
		uop = CELL_HOLD;
		if (state_q == ST_INSERT && !full) begin
			if (to_lower) begin
				lop = CELL_INSERT;
			end else begin
				uop = CELL_INSERT;
			end
		end else if (state_q == ST_BALANCE) begin
			if (lower_heavy) begin
				lop = CELL_POP;
				uop = CELL_PUSH;
			end else if (upper_heavy) begin
				uop = CELL_POP;
				lop = CELL_PUSH;
			end
		end
	end

	always_comb begin
		if (lsize_q == usize_q) begin
			median = (lsize_q == '0) ? '0 : MED_W'(ltop) + MED_W'(utop);
		end else if (lsize_q > usize_q) begin
			median = MED_W'(ltop) <<< 1;
		end else begin
			median = MED_W'(utop) <<< 1;
		end
	end

	rmth_chain u_lower (
		.clk  (clk),
		.op   (lop),
		.desc (1'b1),
		.din  (ldin),
		.size (lsize_q),
		.top  (ltop)
	);

	rmth_chain u_upper (
		.clk  (clk),
		.op   (uop),
		.desc (1'b0),
		.din  (udin),
		.size (usize_q),
		.top  (utop)
	);

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_q <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			lsize_q        <= '0;
			usize_q        <= '0;
			rej_q          <= 1'b0;
			out_valid      <= 1'b0;
			median_doubled <= '0;
			sample_count   <= '0;
			rejected       <= 1'b0;
		end else begin
			if (out_valid && out_ready && state_q != ST_DONE) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_INSERT;
					end
				end
				ST_INSERT: begin
					rej_q <= full;
					if (!full) begin
						if (to_lower) begin
							lsize_q <= lsize_q + 1'b1;
						end else begin
							usize_q <= usize_q + 1'b1;
						end
					end
					state_q <= ST_BALANCE;
				end
				ST_BALANCE: begin
					if (lower_heavy) begin
						lsize_q <= lsize_q - 1'b1;
						usize_q <= usize_q + 1'b1;
					end else if (upper_heavy) begin
						usize_q <= usize_q - 1'b1;
						lsize_q <= lsize_q + 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid || out_ready) begin
						median_doubled <= median;
						sample_count   <= COUNT_W'(total);
						rejected       <= rej_q;
						out_valid      <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
